// ----- hdl/assert_macros.svh -----
// Assertion helpers; each expects clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// expr must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// ----- hdl/mi_pkg.sv -----
package mi_pkg;

	localparam int WIDTH = 32;
	// k counts quotient bits of one Euclid step, at most WIDTH-1
	localparam int KW = $clog2(WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_ALIGN,
		ST_REDUCE,
		ST_FIX,
		ST_RESULT
	} mi_state_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_START,
		OP_ALIGN,
		OP_REDUCE,
		OP_FIX
	} mi_op_t;

	typedef struct packed {
		mi_op_t op;
		logic   in_ready;
		logic   load_out;
	} mi_ctl_t;

	typedef struct packed {
		logic r1_zero;
		logic align_more;
		logic k_zero;
	} mi_sts_t;

endpackage

// ----- hdl/mi_req_if.sv -----
interface mi_req_if;
	logic                     valid;
	logic                     ready;
	logic [mi_pkg::WIDTH-1:0] value;
	logic [mi_pkg::WIDTH-1:0] modulus;

	modport source (output valid, output value, output modulus, input ready);
	modport sink (input valid, input value, input modulus, output ready);
endinterface

// ----- hdl/mi_rsp_if.sv -----
interface mi_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [mi_pkg::WIDTH-1:0] inverse;
	logic                     exists;

	modport source (output valid, output inverse, output exists, input ready);
	modport sink (input valid, input inverse, input exists, output ready);
endinterface

// ----- hdl/mi_datapath.sv -----
`include "assert_macros.svh"

module mi_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mi_pkg::mi_ctl_t          ctl,
	input  logic [mi_pkg::WIDTH-1:0] value,
	input  logic [mi_pkg::WIDTH-1:0] modulus,
	output mi_pkg::mi_sts_t          sts,
	output logic [mi_pkg::WIDTH-1:0] inverse,
	output logic                     exists
);

	localparam int W  = mi_pkg::WIDTH;
	localparam int KW = mi_pkg::KW;
	localparam logic [W-1:0] ONE_W  = {{(W-1){1'b0}}, 1'b1};
	localparam logic [W:0]   ONE_W1 = {{W{1'b0}}, 1'b1};

	// r0/r1: remainders, m0/m1: coefficient magnitudes, neg_q: sign of m0
	logic [W-1:0]  r0_q, r1_q, d_q, mod_q;
	logic [W:0]    m0_q, m1_q, c_q;
	logic [KW-1:0] k_q;
	logic          neg_q;

	logic          take;
	logic [W-1:0]  rem_nx;
	logic [W:0]    acc_nx;
	logic [W:0]    mod_ext;
	logic [W:0]    r0_ext;
	logic [W:0]    d_dbl;

	assign take    = (r0_q >= d_q);
	assign rem_nx  = take ? (r0_q - d_q) : r0_q;
	assign acc_nx  = take ? (m0_q + c_q) : m0_q;
	assign mod_ext = {1'b0, mod_q};
	assign r0_ext  = {1'b0, r0_q};
	assign d_dbl   = {d_q, 1'b0};

	assign sts.r1_zero    = (r1_q == '0);
	assign sts.align_more = (d_q <= (r0_q >> 1));
	assign sts.k_zero     = (k_q == '0);

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			mi_pkg::OP_LOAD: begin
				// a zero modulus runs as gcd 0, which yields no inverse
				r0_q  <= (modulus == '0) ? '0 : value;
				r1_q  <= modulus;
				m0_q  <= ONE_W1;
				m1_q  <= '0;
				neg_q <= 1'b0;
				mod_q <= modulus;
			end
			mi_pkg::OP_START: begin
				d_q <= r1_q;
				c_q <= m1_q;
				k_q <= '0;
			end
			mi_pkg::OP_ALIGN: begin
				d_q <= {d_q[W-2:0], 1'b0};
				c_q <= {c_q[W-1:0], 1'b0};
				k_q <= k_q + KW'(1);
			end
			mi_pkg::OP_REDUCE: begin
				if (sts.k_zero) begin
					// last quotient bit: rotate the remainder and coefficient pairs
					r0_q  <= r1_q;
					r1_q  <= rem_nx;
					m0_q  <= m1_q;
					m1_q  <= acc_nx;
					neg_q <= !neg_q;
				end else begin
					r0_q <= rem_nx;
					m0_q <= acc_nx;
					d_q  <= {1'b0, d_q[W-1:1]};
					c_q  <= {1'b0, c_q[W:1]};
					k_q  <= k_q - KW'(1);
				end
			end
			mi_pkg::OP_FIX: begin
				if (m0_q >= mod_ext) begin
					m0_q <= m0_q - mod_ext;
				end
			end
			default: begin
			end
		endcase
	end

	assign exists  = (r0_q == ONE_W);
	assign inverse = (!exists || m0_q == '0) ? '0 :
		(neg_q ? (mod_q - m0_q[W-1:0]) : m0_q[W-1:0]);

	`ASSERT_ALWAYS(a_reduce_bound,
		(ctl.op == mi_pkg::OP_REDUCE |-> r0_ext < d_dbl),
		"remainder not below twice the divisor step")
	`ASSERT_ALWAYS(a_fix_range,
		((ctl.op == mi_pkg::OP_FIX) && exists |=> m0_q < mod_ext),
		"coefficient not reduced below modulus")

endmodule

// ----- hdl/mi_ctrl.sv -----
`include "assert_macros.svh"

module mi_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_free,
	input  mi_pkg::mi_sts_t sts,
	output mi_pkg::mi_ctl_t ctl
);

	mi_pkg::mi_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mi_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			mi_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nx = mi_pkg::ST_START;
				end
			end
			mi_pkg::ST_START: begin
				state_nx = sts.r1_zero ? mi_pkg::ST_FIX : mi_pkg::ST_ALIGN;
			end
			mi_pkg::ST_ALIGN: begin
				if (!sts.align_more) begin
					state_nx = mi_pkg::ST_REDUCE;
				end
			end
			mi_pkg::ST_REDUCE: begin
				if (sts.k_zero) begin
					state_nx = mi_pkg::ST_START;
				end
			end
			mi_pkg::ST_FIX: begin
				state_nx = mi_pkg::ST_RESULT;
			end
			mi_pkg::ST_RESULT: begin
				if (out_free) begin
					state_nx = mi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = mi_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl.op       = mi_pkg::OP_HOLD;
		ctl.in_ready = 1'b0;
		ctl.load_out = 1'b0;
		unique case (state_q)
			mi_pkg::ST_IDLE: begin
				ctl.in_ready = 1'b1;
				if (in_valid) begin
					ctl.op = mi_pkg::OP_LOAD;
				end
			end
			mi_pkg::ST_START: begin
				if (!sts.r1_zero) begin
					ctl.op = mi_pkg::OP_START;
				end
			end
			mi_pkg::ST_ALIGN: begin
				if (sts.align_more) begin
					ctl.op = mi_pkg::OP_ALIGN;
				end
			end
			mi_pkg::ST_REDUCE: begin
				ctl.op = mi_pkg::OP_REDUCE;
			end
			mi_pkg::ST_FIX: begin
				ctl.op = mi_pkg::OP_FIX;
			end
			mi_pkg::ST_RESULT: begin
				ctl.load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	`ASSERT_ALWAYS(a_accept_starts, (ctl.in_ready && in_valid |=> state_q == mi_pkg::ST_START), "accepted item did not start a run")

endmodule

// ----- hdl/modular_inverse.sv -----
// Modular inverse by the extended Euclidean algorithm.
// request channel: value and modulus, taken when valid and ready are both high.
// response channel: inverse in 0..modulus-1 and the exists flag; inverse is 0
// and exists low when gcd(value, modulus) is not 1 or the modulus is zero.
// A modulus of one gives inverse 0 with exists high.
// One item is worked on at a time; request.ready is high only while idle.
// Each Euclid step runs on one shared subtract/shift unit: a set-up, then
// one alignment shift of the divisor per cycle, then one quotient bit per cycle.
// The item is loaded before the first step; a final reduction of the
// coefficient and the hand-off follow the last step.
// The result sits in an output register: while it waits for response.ready
// the next item is already accepted and processed; a finished run holds
// until that register is free.
// Reset clears the sequencer and the response valid flag; no item is pending.
module modular_inverse (
	input  logic        clk,
	input  logic        arst_n,
	mi_req_if.sink      request,
	mi_rsp_if.source    response
);

	mi_pkg::mi_ctl_t          ctl;
	mi_pkg::mi_sts_t          sts;
	logic [mi_pkg::WIDTH-1:0] dp_inverse;
	logic                     dp_exists;
	logic                     out_free;
	logic                     rsp_valid_q;
	logic [mi_pkg::WIDTH-1:0] inverse_q;
	logic                     exists_q;

	assign out_free = !rsp_valid_q || response.ready;

	mi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.out_free (out_free),
		.sts      (sts),
		.ctl      (ctl)
	);

	mi_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.value   (request.value),
		.modulus (request.modulus),
		.sts     (sts),
		.inverse (dp_inverse),
		.exists  (dp_exists)
	);

	assign request.ready = ctl.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (response.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			inverse_q <= dp_inverse;
			exists_q  <= dp_exists;
		end
	end

	assign response.valid   = rsp_valid_q;
	assign response.inverse = inverse_q;
	assign response.exists  = exists_q;

	`ASSERT_ALWAYS(a_no_inverse_zero, (response.valid && !response.exists |-> response.inverse == '0), "nonzero inverse without exists")
	`ASSERT_NEVER(a_accept_vs_load, (request.valid && request.ready && ctl.load_out), "item accepted while a result is loaded")

endmodule
